[rtl/sha_pkg.sv]
// shared types, constants and round functions of the sha-256 hasher
package sha_pkg;

  typedef logic [7:0][31:0] words_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       init;
    logic       step;
    logic [5:0] rnd;
  } sha_ctl_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned WordAw     = $clog2(BlockWords);
  localparam int unsigned CntW       = 61;

  localparam logic [31:0] PadByteWord = 32'h8000_0000;

  // word 0 in element 0
  localparam words_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x};
    return dbl[n +: 32];
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[rtl/sha_if.sv]
// valid/ready channel interfaces for byte input and digest output
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

[rtl/sha256_byte_stream_hasher.sv]
// sha-256 byte stream hasher: byte packing, padding sequencer and digest output
// a message byte is taken only in the idle state; a full block then blocks input while
//   the ram read is primed, the 64 rounds run and the hash words are updated
// a finish writes the padding words and compresses one or two blocks, then gives
//   eight digest words at one per cycle while the output is taken
// the single shared round unit holds input off until a full block is compressed
// reset: hash words to the initial values, fill and length to zero; the block ram
//   is not cleared, every word is written before it is read
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [5:0]          fill_q;
  logic [23:0]         acc_q;
  logic [CntW-1:0]     cnt_q;
  logic [WordAw-1:0]   wr_idx_q;
  logic                two_blk_q;
  logic                fin_q;
  logic [5:0]          rnd_q;
  logic [2:0]          out_idx_q;
  words_t              hash_q;
  logic                out_valid_q;
  logic [31:0]         out_word_q;
  logic [2:0]          out_index_q;
  logic                out_last_q;

  logic                accept;
  logic                ram_we;
  logic [WordAw-1:0]   ram_waddr;
  logic [31:0]         ram_wdata;
  logic [WordAw-1:0]   ram_raddr;
  logic [31:0]         ram_rdata;
  logic [31:0]         pad_word;
  logic [63:0]         bit_len;
  sha_ctl_t            ctl;
  words_t              vars;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign bit_len    = {cnt_q, 3'b000};

  // partial word closed by the 0x80 marker
  always_comb begin
    case (fill_q[1:0])
      2'd0:    pad_word = PadByteWord;
      2'd1:    pad_word = {acc_q[7:0], 8'h80, 16'h0000};
      2'd2:    pad_word = {acc_q[15:0], 8'h80, 8'h00};
      2'd3:    pad_word = {acc_q[23:0], 8'h80};
      default: pad_word = PadByteWord;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_q[5:2];
    ram_wdata = {acc_q, in_i.data_byte};
    if (state_q == S_IDLE && accept) begin
      if (in_i.kind) begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
      end else begin
        ram_we = (fill_q[1:0] == 2'd3);
      end
    end else if (state_q == S_PAD) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx_q;
      if (!two_blk_q && wr_idx_q == WordAw'(BlockWords - 2)) begin
        ram_wdata = bit_len[63:32];
      end else if (!two_blk_q && wr_idx_q == WordAw'(BlockWords - 1)) begin
        ram_wdata = bit_len[31:0];
      end else begin
        ram_wdata = '0;
      end
    end
  end

  // the read for round t+1 is issued during round t
  assign ram_raddr = (state_q == S_ROUND) ? WordAw'(rnd_q + 6'd1) : '0;

  assign ctl.init = (state_q == S_LOAD);
  assign ctl.step = (state_q == S_ROUND);
  assign ctl.rnd  = rnd_q;

  sha_ram #(
    .Width (32),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sha_core u_core (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .hash_i  (hash_q),
    .rdata_i (ram_rdata),
    .vars_o  (vars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      wr_idx_q    <= '0;
      two_blk_q   <= 1'b0;
      fin_q       <= 1'b0;
      rnd_q       <= '0;
      out_idx_q   <= '0;
      hash_q      <= HashInit;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_index_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // in the output phase the word register is reloaded below
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.kind) begin
              fin_q     <= 1'b1;
              fill_q    <= '0;
              two_blk_q <= (fill_q[5:2] >= 4'(BlockWords - 2));
              wr_idx_q  <= fill_q[5:2] + 4'd1;
              // marker landed in the last word: nothing more to write now
              if (fill_q[5:2] == 4'(BlockWords - 1)) begin
                state_q <= S_LOAD;
              end else begin
                state_q <= S_PAD;
              end
            end else begin
              acc_q  <= {acc_q[15:0], in_i.data_byte};
              fill_q <= fill_q + 6'd1;
              cnt_q  <= cnt_q + CntW'(1);
              fin_q  <= 1'b0;
              if (fill_q == 6'd63) begin
                state_q <= S_LOAD;
              end
            end
          end
        end
        S_PAD: begin
          wr_idx_q <= wr_idx_q + 4'd1;
          if (wr_idx_q == 4'(BlockWords - 1)) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd_q   <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + vars[i];
          end
          if (two_blk_q) begin
            two_blk_q <= 1'b0;
            wr_idx_q  <= '0;
            state_q   <= S_PAD;
          end else if (fin_q) begin
            out_idx_q <= '0;
            state_q   <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_word_q  <= hash_q[out_idx_q];
            out_index_q <= out_idx_q;
            out_last_q  <= (out_idx_q == 3'd7);
            out_idx_q   <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              hash_q  <= HashInit;
              cnt_q   <= '0;
              fin_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = out_word_q;
  assign out_o.word_index  = out_index_q;
  assign out_o.last_word   = out_last_q;

`ifndef SYNTH
  a_no_write_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND || state_q == S_LOAD) |-> !ram_we)
    else $error("block ram written while compressing");

  a_rounds_then_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FINAL))
    else $error("round 63 not followed by hash update");

  a_out_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("digest word presented outside output phase");

  a_fill_clear_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (fill_q == 6'd0 && !two_blk_q))
    else $error("block fill not cleared before digest output");
`endif

endmodule

[rtl/sha_ram.sv]
// generic single-write, single-read ram with registered read data
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/sha_core.sv]
// sha-256 round datapath: working variables and message schedule window
module sha_core
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  sha_ctl_t    ctl_i,
  input  words_t      hash_i,
  input  logic [31:0] rdata_i,
  output words_t      vars_o
);

  words_t            v_q;
  logic [15:0][31:0] w_q;
  logic [31:0]       w_new;
  logic [31:0]       t1;
  logic [31:0]       t2;
  logic [31:0]       ch;
  logic [31:0]       maj;

  // first sixteen rounds take block words from the ram, the rest are expanded
  always_comb begin
    if (ctl_i.rnd < 6'd16) begin
      w_new = rdata_i;
    end else begin
      w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
    end
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + bsig1(v_q[4]) + ch + round_k(ctl_i.rnd) + w_new;
    t2  = bsig0(v_q[0]) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      v_q <= hash_i;
    end else if (ctl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      w_q    <= {w_new, w_q[15:1]};
    end
  end

  assign vars_o = v_q;

endmodule
